// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL. Clock i_clk, reset i_rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/fsc_pkg.sv =====
package fsc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_RECIP,
        S_FEED,
        S_DRAIN,
        S_DIV_C,
        S_DIV_S,
        S_EMIT
    } t_state;

    localparam int CORDIC_STEPS = 14;
    localparam int XY_W         = 18;
    localparam int Z_W          = 16;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 18'sd9949;

    localparam int COEFF_W = 18;
    localparam logic signed [COEFF_W-1:0] COEFF_MAX = 18'sd131071;
    localparam logic signed [COEFF_W-1:0] COEFF_MIN = -18'sd131072;
    localparam int COEFF_POS_LIM = 131071;
    localparam int COEFF_NEG_LIM = 131072;

    // one rotation stage's worth of state
    typedef struct packed {
        logic                   vld;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } t_rot;

    // arctan(2^-k) with one turn = 65536
    function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned k);
        logic signed [Z_W-1:0] v;
        case (k)
            0:       v = 16'sd8192;
            1:       v = 16'sd4836;
            2:       v = 16'sd2555;
            3:       v = 16'sd1297;
            4:       v = 16'sd651;
            5:       v = 16'sd326;
            6:       v = 16'sd163;
            7:       v = 16'sd81;
            8:       v = 16'sd41;
            9:       v = 16'sd20;
            10:      v = 16'sd10;
            11:      v = 16'sd5;
            12:      v = 16'sd3;
            13:      v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/fsc_cordic_cell.sv =====
// One rotation step; carries the sample alongside the angle.
module fsc_cordic_cell #(
    parameter int STAGE        = 0,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fsc_pkg::t_rot                  i_rot,
    input  logic signed [SAMPLE_WIDTH-1:0] i_smp,
    output fsc_pkg::t_rot                  o_rot,
    output logic signed [SAMPLE_WIDTH-1:0] o_smp
);

    localparam logic signed [fsc_pkg::Z_W-1:0] ATAN = fsc_pkg::atan_lut(STAGE);

    fsc_pkg::t_rot                  r_rot;
    fsc_pkg::t_rot                  n_rot;
    logic signed [SAMPLE_WIDTH-1:0] r_smp;
    logic signed [fsc_pkg::XY_W-1:0] w_shx;
    logic signed [fsc_pkg::XY_W-1:0] w_shy;

    always_comb begin
        w_shx = i_rot.x >>> STAGE;
        w_shy = i_rot.y >>> STAGE;
        n_rot = i_rot;
        if (!i_rot.z[fsc_pkg::Z_W-1]) begin
            n_rot.x = i_rot.x - w_shy;
            n_rot.y = i_rot.y + w_shx;
            n_rot.z = i_rot.z - ATAN;
        end else begin
            n_rot.x = i_rot.x + w_shy;
            n_rot.y = i_rot.y - w_shx;
            n_rot.z = i_rot.z + ATAN;
        end
    end

    // only the valid bit is reset; the data fields just follow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.vld <= 1'b0;
        end else begin
            r_rot.vld <= n_rot.vld;
        end
        r_rot.x    <= n_rot.x;
        r_rot.y    <= n_rot.y;
        r_rot.z    <= n_rot.z;
        r_rot.quad <= n_rot.quad;
        r_smp      <= i_smp;
    end

    assign o_rot = r_rot;
    assign o_smp = r_smp;

endmodule

// ===== hdl/fsc_divider.sv =====
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
module fsc_divider #(
    parameter int W = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [7:0]   i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [7:0]   o_rem
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [W-1:0]  r_quot;
    logic [7:0]    r_rem;
    logic [7:0]    r_div;
    logic [8:0]    w_trial;
    logic [8:0]    w_diff;
    logic          w_ge;

    always_comb begin
        w_trial = {r_rem, r_quot[W-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[7:0] : w_trial[7:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/fourier_series_coefficients.sv =====
// Fourier series coefficient unit. Samples (signed Q8.8) are loaded one per
// request with i_start while o_busy is low. The request that brings sample
// number n (n = i_cfg_wdata, clamped to 3..MAX_SAMPLES) raises o_busy and
// starts the coefficient pass. Results come out on o_result_valid, one cycle
// each, and cannot be held off: the receiver must take them as they appear.
// Result 0 is the mean a0 (o_sin_coeff = 0), then harmonics 1..m with
// m = (n-2)/2 rounded down; o_last_result marks the final one. A reciprocal
// step (65536 / n) comes first, then each of the m+1 harmonic passes runs
// through the rotation chain plus one divide (harmonic 0) or two divides
// (harmonics 1..m) on a divider of width W = SAMPLE_WIDTH + 14 (30 at
// defaults). The rotation chain and the single shared divider set the pace.
// Write i_cfg_wdata only while o_busy is low.
`include "assert_macros.svh"

module fourier_series_coefficients #(
    parameter int MAX_SAMPLES  = 128,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [7:0]                              i_cfg_wdata,
    input  logic                                    i_start,
    input  logic signed [SAMPLE_WIDTH-1:0]          i_sample,
    output logic                                    o_busy,
    output logic                                    o_result_valid,
    output logic [5:0]                              o_harmonic_index,
    output logic signed [fsc_pkg::COEFF_W-1:0]      o_cos_coeff,
    output logic signed [fsc_pkg::COEFF_W-1:0]      o_sin_coeff,
    output logic                                    o_last_result
);

    localparam int AW        = $clog2(MAX_SAMPLES);
    localparam int PROD_W    = SAMPLE_WIDTH + fsc_pkg::XY_W;
    localparam int ACC_W     = SAMPLE_WIDTH + fsc_pkg::XY_W + 8;
    localparam int DIV_W     = ACC_W - 12;
    localparam int DRAIN_LEN = fsc_pkg::CORDIC_STEPS + 5;
    localparam int NST       = fsc_pkg::CORDIC_STEPS;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    fsc_pkg::t_state r_state;
    fsc_pkg::t_state n_state;

    logic [7:0]  r_cfg_n;      // programmed sample count
    logic [7:0]  r_n;          // count latched for the running block
    logic [5:0]  r_m;          // last harmonic index
    logic [7:0]  r_loaded;     // samples loaded in this block
    logic [5:0]  r_harm;       // harmonic being computed
    logic [7:0]  r_j;          // sample address being fed
    logic [4:0]  r_drain;

    // phase generation: phase = floor(idx * 65536 / n), tracked as quotient/remainder
    logic [15:0] r_ph1;        // 65536 / n
    logic [7:0]  r_rem1;       // 65536 mod n
    logic [15:0] r_step_ph;    // per-sample phase step of this harmonic
    logic [7:0]  r_step_rem;
    logic [15:0] r_next_ph;    // step of the following harmonic
    logic [7:0]  r_next_rem;
    logic [15:0] r_phase;
    logic [7:0]  r_phase_rem;

    logic signed [SAMPLE_WIDTH-1:0] r_mem [MAX_SAMPLES];
    logic signed [SAMPLE_WIDTH-1:0] r_rd;
    logic        r_feed_vld;
    logic [15:0] r_feed_ph;

    // post-chain pipeline
    logic                            r_q_vld;
    logic signed [fsc_pkg::XY_W-1:0] r_q_c;
    logic signed [fsc_pkg::XY_W-1:0] r_q_s;
    logic signed [SAMPLE_WIDTH-1:0]  r_q_smp;
    logic                            r_pr_vld;
    logic signed [PROD_W-1:0]        r_prod_c;
    logic signed [PROD_W-1:0]        r_prod_s;
    logic signed [ACC_W-1:0]         r_acc_c;
    logic signed [ACC_W-1:0]         r_acc_s;

    logic                              r_neg;
    logic signed [fsc_pkg::COEFF_W-1:0] r_cos_res;
    logic signed [fsc_pkg::COEFF_W-1:0] r_sin_res;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic        w_accept;
    logic [7:0]  w_loaded_nx;
    logic [7:0]  w_n_eff;
    logic        w_block_done;
    logic        w_feed_last;
    logic        w_drain_end;
    logic        w_last_harm;

    logic             w_div_start;
    logic [DIV_W-1:0] w_div_dividend;
    logic [7:0]       w_div_divisor;
    logic             w_div_busy;
    logic             w_div_done;
    logic [DIV_W-1:0] w_div_quot;
    logic [7:0]       w_div_rem;

    logic signed [ACC_W-1:0] w_sel_acc;
    logic [ACC_W-1:0]        w_mag;
    logic [ACC_W:0]          w_sum_h;
    logic [DIV_W-1:0]        w_x;
    logic signed [fsc_pkg::COEFF_W-1:0] w_sat;

    logic [8:0]  w_ph_sum;
    logic        w_ph_cy;
    logic [8:0]  w_nx_sum;
    logic        w_nx_cy;

    fsc_pkg::t_rot                  w_rot [NST+1];
    logic signed [SAMPLE_WIDTH-1:0] w_smp [NST+1];
    logic signed [fsc_pkg::XY_W-1:0] w_c;
    logic signed [fsc_pkg::XY_W-1:0] w_s;

    always_comb begin
        if (r_cfg_n < 8'd3) begin
            w_n_eff = 8'd3;
        end else if (r_cfg_n > 8'(MAX_SAMPLES)) begin
            w_n_eff = 8'(MAX_SAMPLES);
        end else begin
            w_n_eff = r_cfg_n;
        end
    end

    assign w_accept     = i_start && !o_busy;
    assign w_loaded_nx  = r_loaded + 8'd1;
    assign w_block_done = w_accept && (w_loaded_nx >= w_n_eff);
    assign w_feed_last  = (r_j == r_n - 8'd1);
    assign w_drain_end  = (r_drain == 5'(DRAIN_LEN - 1));
    assign w_last_harm  = (r_harm == r_m);

    // phase advance within a pass and between harmonics (remainders stay below n)
    always_comb begin
        w_ph_sum = {1'b0, r_phase_rem} + {1'b0, r_step_rem};
        w_ph_cy  = (w_ph_sum >= {1'b0, r_n});
        w_nx_sum = {1'b0, r_next_rem} + {1'b0, r_rem1};
        w_nx_cy  = (w_nx_sum >= {1'b0, r_n});
    end

    // divider operand: rounding offset folded into the dividend
    always_comb begin
        w_sel_acc = (r_state == fsc_pkg::S_DIV_C) ? r_acc_s : r_acc_c;
        w_mag     = w_sel_acc[ACC_W-1] ? unsigned'(ACC_W'(-w_sel_acc))
                                       : unsigned'(ACC_W'(w_sel_acc));
        w_sum_h   = {1'b0, w_mag} + (ACC_W+1)'({r_n, 12'b0});
        if (r_harm == 6'd0) begin
            w_x = DIV_W'(w_mag + ACC_W'(r_n[7:1]));
        end else begin
            w_x = w_sum_h[ACC_W:13];
        end
    end

    // signed, saturated quotient
    always_comb begin
        if (r_neg) begin
            if (w_div_quot > DIV_W'(fsc_pkg::COEFF_NEG_LIM)) begin
                w_sat = fsc_pkg::COEFF_MIN;
            end else begin
                w_sat = -signed'(fsc_pkg::COEFF_W'(w_div_quot));
            end
        end else begin
            if (w_div_quot > DIV_W'(fsc_pkg::COEFF_POS_LIM)) begin
                w_sat = fsc_pkg::COEFF_MAX;
            end else begin
                w_sat = signed'(fsc_pkg::COEFF_W'(w_div_quot));
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsc_pkg::S_LOAD: begin
                if (w_block_done) n_state = fsc_pkg::S_RECIP;
            end
            fsc_pkg::S_RECIP: begin
                if (w_div_done) n_state = fsc_pkg::S_FEED;
            end
            fsc_pkg::S_FEED: begin
                if (w_feed_last) n_state = fsc_pkg::S_DRAIN;
            end
            fsc_pkg::S_DRAIN: begin
                if (w_drain_end) n_state = fsc_pkg::S_DIV_C;
            end
            fsc_pkg::S_DIV_C: begin
                if (w_div_done) begin
                    n_state = (r_harm == 6'd0) ? fsc_pkg::S_EMIT : fsc_pkg::S_DIV_S;
                end
            end
            fsc_pkg::S_DIV_S: begin
                if (w_div_done) n_state = fsc_pkg::S_EMIT;
            end
            fsc_pkg::S_EMIT: begin
                n_state = w_last_harm ? fsc_pkg::S_LOAD : fsc_pkg::S_FEED;
            end
            default: n_state = fsc_pkg::S_LOAD;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs and divider control
    // ---------------------------------------------------------------
    always_comb begin
        o_busy         = (r_state != fsc_pkg::S_LOAD);
        o_result_valid = (r_state == fsc_pkg::S_EMIT);
        w_div_start    = 1'b0;
        w_div_dividend = w_x;
        w_div_divisor  = r_n;
        unique case (r_state)
            fsc_pkg::S_LOAD: begin
                // 65536 / n gives the phase step of the first harmonic
                w_div_start    = w_block_done;
                w_div_dividend = DIV_W'(17'h10000);
                w_div_divisor  = w_n_eff;
            end
            fsc_pkg::S_DRAIN: begin
                w_div_start = w_drain_end;
            end
            fsc_pkg::S_DIV_C: begin
                w_div_start = w_div_done && (r_harm != 6'd0);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    fsc_divider #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // ---------------------------------------------------------------
    // Sample store
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_loaded < 8'(MAX_SAMPLES))) begin
            r_mem[r_loaded[AW-1:0]] <= i_sample;
        end
        r_rd <= r_mem[r_j[AW-1:0]];
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fsc_pkg::S_LOAD;
            r_cfg_n    <= 8'd25;
            r_loaded   <= '0;
            r_harm     <= '0;
            r_j        <= '0;
            r_drain    <= '0;
            r_feed_vld <= 1'b0;
            r_q_vld    <= 1'b0;
            r_pr_vld   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_feed_vld <= (r_state == fsc_pkg::S_FEED);
            r_q_vld    <= w_rot[NST].vld;
            r_pr_vld   <= r_q_vld;
            if (i_cfg_we) begin
                r_cfg_n <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_loaded <= w_block_done ? 8'd0 : w_loaded_nx;
            end
            if (r_state == fsc_pkg::S_FEED) begin
                r_j     <= r_j + 8'd1;
                r_drain <= '0;
            end
            if (r_state == fsc_pkg::S_DRAIN) begin
                r_drain <= r_drain + 5'd1;
            end
            if (r_state == fsc_pkg::S_RECIP && w_div_done) begin
                r_harm <= '0;
                r_j    <= '0;
            end
            if (r_state == fsc_pkg::S_EMIT && !w_last_harm) begin
                r_harm <= r_harm + 6'd1;
                r_j    <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_block_done) begin
            r_n <= w_n_eff;
            r_m <= 6'((w_n_eff - 8'd2) >> 1);
        end
        if (r_state == fsc_pkg::S_RECIP && w_div_done) begin
            r_ph1      <= w_div_quot[15:0];
            r_rem1     <= w_div_rem;
            r_next_ph  <= w_div_quot[15:0];
            r_next_rem <= w_div_rem;
        end
        if (r_state == fsc_pkg::S_EMIT && !w_last_harm) begin
            r_phase     <= r_next_ph;
            r_phase_rem <= r_next_rem;
            r_step_ph   <= r_next_ph;
            r_step_rem  <= r_next_rem;
            r_next_ph   <= r_next_ph + r_ph1 + 16'(w_nx_cy);
            r_next_rem  <= w_nx_cy ? 8'(w_nx_sum - {1'b0, r_n}) : w_nx_sum[7:0];
        end
        if (r_state == fsc_pkg::S_FEED) begin
            r_feed_ph   <= r_phase;
            r_phase     <= r_phase + r_step_ph + 16'(w_ph_cy);
            r_phase_rem <= w_ph_cy ? 8'(w_ph_sum - {1'b0, r_n}) : w_ph_sum[7:0];
        end

        // accumulators restart at the head of every pass
        if ((r_state == fsc_pkg::S_RECIP && w_div_done) ||
            (r_state == fsc_pkg::S_EMIT && !w_last_harm)) begin
            r_acc_c <= '0;
            r_acc_s <= '0;
        end else if (r_pr_vld) begin
            r_acc_c <= r_acc_c + ACC_W'(r_prod_c);
            r_acc_s <= r_acc_s + ACC_W'(r_prod_s);
        end

        if (w_div_start) begin
            r_neg <= w_sel_acc[ACC_W-1];
        end
        if (r_state == fsc_pkg::S_DIV_C && w_div_done) begin
            r_cos_res <= w_sat;
            if (r_harm == 6'd0) begin
                r_sin_res <= '0;
            end
        end
        if (r_state == fsc_pkg::S_DIV_S && w_div_done) begin
            r_sin_res <= w_sat;
        end
    end

    // ---------------------------------------------------------------
    // Rotation chain: one cell per CORDIC step, sample rides along
    // ---------------------------------------------------------------
    always_comb begin
        w_rot[0].vld  = r_feed_vld;
        w_rot[0].x    = fsc_pkg::CORDIC_X0;
        w_rot[0].y    = '0;
        w_rot[0].z    = signed'({2'b00, r_feed_ph[13:0]});
        w_rot[0].quad = r_feed_ph[15:14];
        w_smp[0]      = r_rd;
    end

    for (genvar k = 0; k < NST; k++) begin : g_cell
        fsc_cordic_cell #(
            .STAGE        (k),
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rot   (w_rot[k]),
            .i_smp   (w_smp[k]),
            .o_rot   (w_rot[k+1]),
            .o_smp   (w_smp[k+1])
        );
    end

    // quadrant map
    always_comb begin
        case (w_rot[NST].quad)
            2'd0: begin
                w_c = w_rot[NST].x;
                w_s = w_rot[NST].y;
            end
            2'd1: begin
                w_c = -w_rot[NST].y;
                w_s = w_rot[NST].x;
            end
            2'd2: begin
                w_c = -w_rot[NST].x;
                w_s = -w_rot[NST].y;
            end
            default: begin
                w_c = w_rot[NST].y;
                w_s = -w_rot[NST].x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q_c   <= w_c;
        r_q_s   <= w_s;
        r_q_smp <= w_smp[NST];
        // mean pass sums raw samples
        if (r_harm == 6'd0) begin
            r_prod_c <= PROD_W'(r_q_smp);
            r_prod_s <= '0;
        end else begin
            r_prod_c <= r_q_smp * r_q_c;
            r_prod_s <= r_q_smp * r_q_s;
        end
    end

    // ---------------------------------------------------------------
    // Result ports
    // ---------------------------------------------------------------
    assign o_harmonic_index = r_harm;
    assign o_cos_coeff      = r_cos_res;
    assign o_sin_coeff      = r_sin_res;
    assign o_last_result    = o_result_valid && w_last_harm;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_IMP(a_div_start_idle, w_div_start, !w_div_busy)
    `ASSERT_IMP(a_mean_sin_zero, o_result_valid && (o_harmonic_index == 6'd0), o_sin_coeff == '0)
    `ASSERT_NXT(a_feed_to_drain, (r_state == fsc_pkg::S_FEED) && w_feed_last, r_state == fsc_pkg::S_DRAIN)
    `ASSERT_IMP(a_chain_empty_div, r_state == fsc_pkg::S_DIV_C, !r_pr_vld && !r_q_vld)

endmodule

// ===== tb/fsc_checker.sv =====
`timescale 1ns / 100ps

module fsc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_start,
    input  logic signed [15:0] i_sample,
    input  logic               i_busy,
    input  logic               i_result_valid,
    input  logic [5:0]         i_harmonic_index,
    input  logic signed [17:0] i_cos_coeff,
    input  logic signed [17:0] i_sin_coeff,
    input  logic               i_last_result,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);

    typedef struct packed {
        logic [5:0]         idx;
        logic signed [17:0] cos_c;
        logic signed [17:0] sin_c;
        logic               last;
    } t_coeff;

    localparam int ATAN [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                                 5, 3, 1};

    t_coeff              coeff_q[$];
    logic [7:0]          block_len;
    logic signed [15:0]  sample_mem [128];
    logic [7:0]          loaded;

    // floor shift, as the rotation unit does
    function automatic int floor_shr(int v, int k);
        return v >>> k;
    endfunction

    function automatic void rotate_phase(input int unsigned p, output int c, output int s);
        int x, y, z, nx, ny;
        x = 9949; y = 0; z = p & 16'h3FFF;
        for (int k = 0; k < 14; k++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, k); ny = y + floor_shr(x, k); z -= ATAN[k];
            end else begin
                nx = x + floor_shr(y, k); ny = y - floor_shr(x, k); z += ATAN[k];
            end
            x = nx; y = ny;
        end
        case ((p >> 14) & 3)
            0:       begin c = x;  s = y;  end
            1:       begin c = -y; s = x;  end
            2:       begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    // nearest, ties away from zero, then clipped to 18 bits
    function automatic logic signed [17:0] round_div(longint num, longint den);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) q = -q;
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return q[17:0];
    endfunction

    task automatic predict_coeffs();
        int n, m, c, s;
        longint acc_c, acc_s;
        t_coeff e;
        n = (block_len < 3) ? 3 : ((block_len > 128) ? 128 : block_len);
        m = (n % 2) ? (n - 1) / 2 - 1 : n / 2 - 1;
        acc_c = 0;
        for (int j = 0; j < n; j++) acc_c += sample_mem[j];
        e.idx = '0; e.cos_c = round_div(acc_c, n); e.sin_c = '0; e.last = (m == 0);
        coeff_q.push_back(e);
        for (int i = 1; i <= m; i++) begin
            acc_c = 0; acc_s = 0;
            for (int j = 1; j <= n; j++) begin
                rotate_phase(32'(((longint'((j * i) % n)) << 16) / n), c, s);
                acc_c += longint'(sample_mem[j-1]) * c;
                acc_s += longint'(sample_mem[j-1]) * s;
            end
            e.idx = 6'(i);
            e.cos_c = round_div(2 * acc_c, longint'(n) << 14);
            e.sin_c = round_div(2 * acc_s, longint'(n) << 14);
            e.last = (i == m);
            coeff_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_coeff e;
        int n;
        if (!i_rst_n) begin
            block_len <= 8'd25;
            loaded = '0;
            coeff_q.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_result_valid) begin
                o_results_seen <= o_results_seen + 1;
                if (coeff_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected coefficient idx=%0d", $realtime,
                                 i_harmonic_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = coeff_q.pop_front();
                    if (e.idx !== i_harmonic_index || e.cos_c !== i_cos_coeff ||
                        e.sin_c !== i_sin_coeff || e.last !== i_last_result) begin
                        if (o_fail_count < 10)
                            $display({"%0t: coeff mismatch exp idx=%0d a=%0d b=%0d last=%0b",
                                      " got idx=%0d a=%0d b=%0d last=%0b"},
                                     $realtime, e.idx, e.cos_c, e.sin_c, e.last,
                                     i_harmonic_index, i_cos_coeff, i_sin_coeff,
                                     i_last_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                n = (block_len < 3) ? 3 : ((block_len > 128) ? 128 : block_len);
                if (loaded < 8'd128) sample_mem[loaded[6:0]] = i_sample;
                loaded = loaded + 8'd1;
                if (loaded >= n) begin
                    predict_coeffs();
                    loaded = '0;
                end
            end
            if (i_cfg_we) block_len <= i_cfg_wdata;
        end
        o_pending <= coeff_q.size();
    end

endmodule

// ===== tb/fourier_series_coefficients_tb.sv =====
`timescale 1ns / 100ps

module fourier_series_coefficients_tb;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [7:0]         i_cfg_wdata = 8'd0;
    logic               i_start = 1'b0;
    logic signed [15:0] i_sample = 16'sd0;
    logic               o_busy;
    logic               o_result_valid;
    logic [5:0]         o_harmonic_index;
    logic signed [17:0] o_cos_coeff;
    logic signed [17:0] o_sin_coeff;
    logic               o_last_result;

    int fail_count, pending, results_seen;
    int samples_sent = 0;
    int sender_idle_pct = 15;
    int quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 100000;

    always #4 i_clk = ~i_clk;

    fourier_series_coefficients DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (i_start),
        .i_sample         (i_sample),
        .o_busy           (o_busy),
        .o_result_valid   (o_result_valid),
        .o_harmonic_index (o_harmonic_index),
        .o_cos_coeff      (o_cos_coeff),
        .o_sin_coeff      (o_sin_coeff),
        .o_last_result    (o_last_result)
    );

    fsc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (i_start),
        .i_sample         (i_sample),
        .i_busy           (o_busy),
        .i_result_valid   (o_result_valid),
        .i_harmonic_index (o_harmonic_index),
        .i_cos_coeff      (o_cos_coeff),
        .i_sin_coeff      (o_sin_coeff),
        .i_last_result    (o_last_result),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_seen   (results_seen)
    );

    // Watchdog: counts cycles with no request or result accepted.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_result_valid || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, pending=%0d", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One sample request; start is dropped during idle cycles and held until accepted.
    task automatic send_sample(input logic signed [15:0] val);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_sample <= val;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        samples_sent++;
    endtask

    // Drain: wait for every coefficient and for o_busy to drop, then idle on.
    task automatic wait_idle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_block_len(input logic [7:0] n);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Full block of random samples; bias some blocks toward full-scale values.
    task automatic send_block(input int n);
        int kind;
        kind = $urandom_range(3, 0);
        for (int k = 0; k < n; k++) begin
            case (kind)
                0:       send_sample(16'($urandom));
                1:       send_sample($urandom_range(1, 0) ? 16'sh7FFF : -16'sh8000);
                2:       send_sample(16'($signed($urandom_range(512, 0)) - 256));
                default: send_sample(16'($urandom) >>> $urandom_range(15, 0));
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: smallest block at the extremes (one result, a0 only).
        set_block_len(8'd3);
        send_sample(16'sh7FFF); send_sample(16'sh7FFF); send_sample(16'sh7FFF);
        wait_idle();
        send_sample(-16'sh8000); send_sample(-16'sh8000); send_sample(-16'sh8000);
        wait_idle();
        // Counts below the floor act as 3.
        set_block_len(8'd0);
        send_sample(16'sh0001); send_sample(-16'sh0001); send_sample(16'sh5555);
        wait_idle();
        // Even n = 4, still a single harmonic window edge.
        set_block_len(8'd4);
        send_sample(16'sh7FFF); send_sample(-16'sh8000);
        send_sample(16'sh7FFF); send_sample(-16'sh8000);
        wait_idle();
        // n = 6: first block with two harmonics (m = 2).
        set_block_len(8'd6);
        for (int k = 0; k < 6; k++) send_sample(k[0] ? 16'shAAAA : 16'sh5555);
        wait_idle();

        // Count lowered mid block: block closes on the next request.
        set_block_len(8'd9);
        for (int k = 0; k < 5; k++) send_sample(16'($urandom));
        wait_idle();
        set_block_len(8'd3);
        send_sample(16'($urandom));
        wait_idle();

        // Random phase 1: sender idles 15%.
        sender_idle_pct = 15;
        set_block_len(8'd255);  // saturates to 128, the largest block
        send_block(128);
        wait_idle();
        // Phase 2: sender idles 70%.
        sender_idle_pct = 70;
        set_block_len(8'($urandom_range(8, 3)));
        send_block(3 + $urandom_range(5, 0));
        wait_idle();
        // Phase 3: no idling, back-to-back blocks at a fixed count.
        sender_idle_pct = 0;
        set_block_len(8'd4);
        for (int b = 0; b < 2; b++) send_block(4);
        wait_idle();

        $display("%0d samples loaded, %0d coefficients checked over block sizes 3..128",
                 samples_sent, results_seen);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
